// ----- design/dual_deque_stack_engine_macros.svh -----
// Assertion macros for the dual deque engine.
`ifndef DUAL_DEQUE_STACK_ENGINE_MACROS_SVH
`define DUAL_DEQUE_STACK_ENGINE_MACROS_SVH

`ifndef SYNTH
`define DDE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dde assertion failed");
`define DDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dde assertion failed");
`else
`define DDE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DDE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/dde_pkg.sv -----
package dde_pkg;

  localparam int DEQUE_DEPTH = 512;
  localparam int AW = $clog2(DEQUE_DEPTH);
  localparam int CW = $clog2(DEQUE_DEPTH + 1);
  localparam int DW = 32;

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEQUE_DEPTH);
  localparam cnt_t TWO_CNT = cnt_t'(2);
  localparam idx_t LAST_IDX = idx_t'(DEQUE_DEPTH - 1);
  localparam logic [CW:0] DEPTH_WIDE = (CW + 1)'(DEQUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_SWAP       = 3'd4,
    MODE_ROT_DOWN   = 3'd5,
    MODE_ROT_UP     = 3'd6,
    MODE_TRANSFER   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_FEW   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ2,
    ST_DATA,
    ST_SWAP_W1,
    ST_SWAP_W2
  } state_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  sel;
    logic                  rd;
    logic signed [DW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [DW-1:0]  value;
    status_t               status;
    cnt_t                  count_a;
    cnt_t                  count_b;
  } res_t;

  function automatic idx_t idx_add(idx_t h, cnt_t f);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, f};
    if (s >= DEPTH_WIDE) begin
      s = s - DEPTH_WIDE;
    end
    return s[AW-1:0];
  endfunction

  function automatic idx_t idx_dec(idx_t h);
    return (h == '0) ? LAST_IDX : h - 1'b1;
  endfunction

  function automatic idx_t idx_inc(idx_t h);
    return (h == LAST_IDX) ? '0 : h + 1'b1;
  endfunction

endpackage

// ----- design/dde_ram.sv -----
module dde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/dde_front.sv -----
module dde_front import dde_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           mode,
  input  logic                 which_deque,
  input  logic signed [DW-1:0] push_value,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_take
);

  cmd_t       slot [2];
  cmd_t       incoming;
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       accept;

  always_comb begin
    incoming.mode  = mode_t'(mode);
    incoming.sel   = which_deque;
    incoming.value = push_value;
    case (incoming.mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT: incoming.rd = 1'b0;
      default:                         incoming.rd = 1'b1;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot[rp];

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (accept) begin
        wp <= ~wp;
      end
      if (cmd_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, cmd_take};
    end
  end

endmodule

// ----- design/dde_back.sv -----
module dde_back import dde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_empty,
  input  logic res_pop,
  output res_t res
);

  state_t state, state_next;
  idx_t   head_a, head_b, head_a_next, head_b_next;
  cnt_t   fill_a, fill_b, fill_a_next, fill_b_next;
  cmd_t   cur;
  idx_t   t_idx, u_idx, t_idx_next, u_idx_next;
  logic signed [DW-1:0] hold_val, hold_next;

  res_t       res_mem [2];
  res_t       res_in;
  logic       res_push;
  logic       res_take;
  logic [1:0] res_cnt;
  logic       res_wp, res_rp;

  logic          we_a, we_b, re_a, re_b;
  logic          we_d, we_o, re_d;
  idx_t          waddr, raddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata_a, rdata_b;
  logic signed [DW-1:0] rdata_sel;

  logic    start;
  logic    act_sel;
  idx_t    dhead, ohead, dback;
  cnt_t    dfill, ofill;
  status_t start_status;
  idx_t    new_dhead;
  cnt_t    new_dfill, new_ofill;

  dde_ram #(.WIDTH(DW), .DEPTH(DEQUE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  dde_ram #(.WIDTH(DW), .DEPTH(DEQUE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_b),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // decode the command at the head of the queue
  always_comb begin
    start     = (state == ST_IDLE) && cmd_valid && (res_cnt != 2'd2);
    act_sel   = (state == ST_IDLE) ? cmd.sel : cur.sel;
    dhead     = cmd.sel ? head_b : head_a;
    ohead     = cmd.sel ? head_a : head_b;
    dfill     = cmd.sel ? fill_b : fill_a;
    ofill     = cmd.sel ? fill_a : fill_b;
    dback     = idx_dec(idx_add(dhead, dfill));
    rdata_sel = cur.sel ? rdata_b : rdata_a;
    unique case (cmd.mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT:
        start_status = (dfill == DEPTH_CNT) ? STAT_FULL : STAT_OK;
      MODE_SWAP:
        start_status = (dfill < TWO_CNT) ? STAT_FEW : STAT_OK;
      MODE_TRANSFER:
        start_status = (dfill == '0) ? STAT_EMPTY :
                       (ofill == DEPTH_CNT) ? STAT_FULL : STAT_OK;
      default:
        start_status = (dfill == '0) ? STAT_EMPTY : STAT_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && start_status == STAT_OK) begin
          if (cmd.mode == MODE_SWAP) begin
            state_next = ST_READ2;
          end else if (cmd.rd) begin
            state_next = ST_DATA;
          end
        end
      end
      ST_READ2:   state_next = ST_SWAP_W1;
      ST_SWAP_W1: state_next = ST_SWAP_W2;
      ST_SWAP_W2: state_next = ST_IDLE;
      ST_DATA:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take     = 1'b0;
    res_push     = 1'b0;
    res_in       = '0;
    we_d         = 1'b0;
    we_o         = 1'b0;
    re_d         = 1'b0;
    waddr        = '0;
    raddr        = '0;
    wdata        = '0;
    t_idx_next   = t_idx;
    u_idx_next   = u_idx;
    hold_next    = hold_val;
    head_a_next  = head_a;
    head_b_next  = head_b;
    fill_a_next  = fill_a;
    fill_b_next  = fill_b;
    new_dhead    = dhead;
    new_dfill    = dfill;
    new_ofill    = ofill;
    unique case (state)
      ST_IDLE: begin
        cmd_take = start;
        if (start) begin
          res_in.status = start_status;
          if (start_status != STAT_OK) begin
            res_push = 1'b1;
          end else begin
            unique case (cmd.mode)
              MODE_PUSH_BACK: begin
                we_d      = 1'b1;
                waddr     = idx_add(dhead, dfill);
                wdata     = cmd.value;
                new_dfill = dfill + 1'b1;
                res_push  = 1'b1;
              end
              MODE_PUSH_FRONT: begin
                we_d      = 1'b1;
                waddr     = idx_dec(dhead);
                wdata     = cmd.value;
                new_dhead = idx_dec(dhead);
                new_dfill = dfill + 1'b1;
                res_push  = 1'b1;
              end
              MODE_POP_BACK: begin
                re_d      = 1'b1;
                raddr     = dback;
                new_dfill = dfill - 1'b1;
              end
              MODE_POP_FRONT: begin
                re_d      = 1'b1;
                raddr     = dhead;
                new_dhead = idx_inc(dhead);
                new_dfill = dfill - 1'b1;
              end
              MODE_SWAP: begin
                re_d       = 1'b1;
                raddr      = dback;
                t_idx_next = dback;
                u_idx_next = idx_dec(dback);
              end
              MODE_ROT_DOWN: begin
                re_d       = 1'b1;
                raddr      = dback;
                t_idx_next = idx_dec(dhead);
                new_dhead  = idx_dec(dhead);
              end
              MODE_ROT_UP: begin
                re_d       = 1'b1;
                raddr      = dhead;
                t_idx_next = idx_add(dhead, dfill);
                new_dhead  = idx_inc(dhead);
              end
              MODE_TRANSFER: begin
                re_d       = 1'b1;
                raddr      = dback;
                t_idx_next = idx_add(ohead, ofill);
                new_dfill  = dfill - 1'b1;
                new_ofill  = ofill + 1'b1;
              end
              default: begin
              end
            endcase
          end
          if (cmd.sel) begin
            head_b_next = new_dhead;
            fill_b_next = new_dfill;
            fill_a_next = new_ofill;
          end else begin
            head_a_next = new_dhead;
            fill_a_next = new_dfill;
            fill_b_next = new_ofill;
          end
        end
      end
      ST_READ2: begin
        re_d      = 1'b1;
        raddr     = u_idx;
        hold_next = rdata_sel;
      end
      ST_SWAP_W1: begin
        we_d      = 1'b1;
        waddr     = u_idx;
        wdata     = hold_val;
        hold_next = rdata_sel;
      end
      ST_SWAP_W2: begin
        we_d         = 1'b1;
        waddr        = t_idx;
        wdata        = hold_val;
        res_push     = 1'b1;
        res_in.value = hold_val;
      end
      ST_DATA: begin
        res_push     = 1'b1;
        res_in.value = rdata_sel;
        wdata        = rdata_sel;
        waddr        = t_idx;
        case (cur.mode) inside
          MODE_ROT_DOWN, MODE_ROT_UP: we_d = 1'b1;
          MODE_TRANSFER:              we_o = 1'b1;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res_in.count_a = fill_a_next;
    res_in.count_b = fill_b_next;
  end

  assign we_a = act_sel ? we_o : we_d;
  assign we_b = act_sel ? we_d : we_o;
  assign re_a = !act_sel && re_d;
  assign re_b = act_sel && re_d;

  assign res_empty = (res_cnt == 2'd0);
  assign res_take  = res_pop && !res_empty;
  assign res       = res_mem[res_rp];

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= cmd;
    end
    t_idx    <= t_idx_next;
    u_idx    <= u_idx_next;
    hold_val <= hold_next;
    if (res_push) begin
      res_mem[res_wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head_a  <= '0;
      head_b  <= '0;
      fill_a  <= '0;
      fill_b  <= '0;
      res_cnt <= 2'd0;
      res_wp  <= 1'b0;
      res_rp  <= 1'b0;
    end else begin
      state  <= state_next;
      head_a <= head_a_next;
      head_b <= head_b_next;
      fill_a <= fill_a_next;
      fill_b <= fill_b_next;
      if (res_push) begin
        res_wp <= ~res_wp;
      end
      if (res_take) begin
        res_rp <= ~res_rp;
      end
      res_cnt <= res_cnt + {1'b0, res_push} - {1'b0, res_take};
    end
  end

endmodule

// ----- design/dual_deque_stack_engine.sv -----
// Two bounded deques, A and B, of signed 32-bit words, each a circular buffer
// in its own single-port-write, single-port-read RAM with registered read.
// Words enter through a two-entry command queue and results leave through a
// two-entry result queue, so either side may stall without stopping the
// other. Operations run one at a time: a push or any failed operation is done
// in the idle state, a pop, rotate or transfer issues the address and then
// takes the registered read data and writes back, and a swap does two reads
// and two writes on the same store RAM. The store RAMs need no clearing after
// reset; only entries already written are ever read.
`include "dual_deque_stack_engine_macros.svh"

module dual_deque_stack_engine import dde_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           mode,
  input  logic                 which_deque,
  input  logic signed [DW-1:0] push_value,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [DW-1:0] value_out,
  output logic [1:0]           status,
  output logic [CW-1:0]        count_a,
  output logic [CW-1:0]        count_b
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  res_t res;

  dde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .which_deque (which_deque),
    .push_value  (push_value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  dde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign value_out = res.value;
  assign status    = res.status;
  assign count_a   = res.count_a;
  assign count_b   = res.count_b;

  `DDE_ASSERT_IMPL(a_take_needs_valid, clk, rst, cmd_take, cmd_valid)
  `DDE_ASSERT_IMPL(a_fail_zero_value, clk, rst, !empty && status != STAT_OK, value_out == '0)
  `DDE_ASSERT_IMPL(a_count_bound, clk, rst, !empty, count_a <= DEPTH_CNT && count_b <= DEPTH_CNT)
  `DDE_ASSERT_NEXT(a_take_frees_slot, clk, rst, cmd_take && !(push && !full), !full)

endmodule

// ----- verif/dual_deque_stack_engine_tb.sv -----
module dual_deque_stack_engine_tb;
  import dde_pkg::*;

  localparam logic DQ_A = 1'b0;
  localparam logic DQ_B = 1'b1;
  localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [DW-1:0] MINV = 32'sh80000000;
  localparam res_t NO_RES = '0;
  localparam int STALL_LIMIT = 200;
  localparam int PLAN_LEN = 25;

  typedef struct {
    mode_t                m;
    logic                 s;
    logic signed [DW-1:0] v;
    bit                   typed;
    res_t                 want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [2:0]           mode = '0;
  logic                 which_deque = 1'b0;
  logic signed [DW-1:0] push_value = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [DW-1:0] value_out;
  logic [1:0]           status;
  logic [CW-1:0]        count_a;
  logic [CW-1:0]        count_b;

  logic signed [DW-1:0] ring [2][DEQUE_DEPTH];
  idx_t                 head [2];
  cnt_t                 fill [2];

  res_t                 outcome_q [$];
  row_t                 plan [PLAN_LEN];
  int                   errors = 0;
  int                   idle_cycles = 0;
  bit                   calm_tx = 1'b0;
  bit                   calm_rx = 1'b0;

  dual_deque_stack_engine uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .which_deque(which_deque),
    .push_value(push_value),
    .empty(empty),
    .pop(pop),
    .value_out(value_out),
    .status(status),
    .count_a(count_a),
    .count_b(count_b)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic idx_t slot_at(logic s, int off);
    return idx_t'((int'(head[s]) + off + DEQUE_DEPTH) % DEQUE_DEPTH);
  endfunction

  function automatic res_t deque_apply(mode_t m, logic s, logic signed [DW-1:0] pv);
    res_t r;
    idx_t t;
    idx_t u;
    logic signed [DW-1:0] x;
    logic o;
    int n;
    int no;
    r = NO_RES;
    r.status = STAT_OK;
    o = ~s;
    n = int'(fill[s]);
    no = int'(fill[o]);
    case (m)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (n >= DEQUE_DEPTH) begin
          r.status = STAT_FULL;
        end else if (m == MODE_PUSH_BACK) begin
          ring[s][slot_at(s, n)] = pv;
          fill[s] = fill[s] + 1'b1;
        end else begin
          head[s] = slot_at(s, -1);
          ring[s][head[s]] = pv;
          fill[s] = fill[s] + 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = ring[s][slot_at(s, n - 1)];
          fill[s] = fill[s] - 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = ring[s][head[s]];
          head[s] = slot_at(s, 1);
          fill[s] = fill[s] - 1'b1;
        end
      end
      MODE_SWAP: begin
        if (n < 2) begin
          r.status = STAT_FEW;
        end else begin
          t = slot_at(s, n - 1);
          u = slot_at(s, n - 2);
          x = ring[s][t];
          ring[s][t] = ring[s][u];
          ring[s][u] = x;
          r.value = ring[s][t];
        end
      end
      MODE_ROT_DOWN: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = ring[s][slot_at(s, n - 1)];
          head[s] = slot_at(s, -1);
          ring[s][head[s]] = r.value;
        end
      end
      MODE_ROT_UP: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = ring[s][head[s]];
          ring[s][slot_at(s, n)] = r.value;
          head[s] = slot_at(s, 1);
        end
      end
      default: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else if (no >= DEQUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          r.value = ring[s][slot_at(s, n - 1)];
          fill[s] = fill[s] - 1'b1;
          ring[o][slot_at(o, no)] = r.value;
          fill[o] = fill[o] + 1'b1;
        end
      end
    endcase
    r.count_a = fill[0];
    r.count_b = fill[1];
    return r;
  endfunction

  task automatic send_word(mode_t m, logic s, logic signed [DW-1:0] v, bit typed,
                           res_t typed_res);
    int gap;
    res_t want;
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
    gap = calm_tx ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    which_deque <= s;
    push_value <= v;
    do @(posedge clk); while (full);
    want = deque_apply(m, s, v);
    if (typed) want = typed_res;
    outcome_q.push_back(want);
  endtask

  task automatic send_random(int push_pct);
    mode_t m;
    if ($urandom_range(0, 99) < push_pct) begin
      m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    end else begin
      m = mode_t'($urandom_range(2, 7));
    end
    send_word(m, 1'($urandom_range(0, 1)), $urandom, 1'b0, NO_RES);
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    res_t want;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
      gap = calm_rx ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: value %0d status %0d counts %0d %0d",
                 $time, value_out, status, count_a, count_b);
      end else begin
        want = outcome_q.pop_front();
        if (value_out !== want.value) begin
          errors++;
          $display("%0t: value_out expected %0d actual %0d", $time, want.value, value_out);
        end
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (count_a !== want.count_a) begin
          errors++;
          $display("%0t: count_a expected %0d actual %0d", $time, want.count_a, count_a);
        end
        if (count_b !== want.count_b) begin
          errors++;
          $display("%0t: count_b expected %0d actual %0d", $time, want.count_b, count_b);
        end
      end
    end
  end

  initial begin
    head = '{'0, '0};
    fill = '{'0, '0};
    plan = '{
      '{MODE_POP_BACK,   DQ_A, 32'sd0, 1'b1, '{32'sd0, STAT_EMPTY, 10'd0, 10'd0}},
      '{MODE_POP_FRONT,  DQ_B, 32'sd0, 1'b1, '{32'sd0, STAT_EMPTY, 10'd0, 10'd0}},
      '{MODE_SWAP,       DQ_A, 32'sd0, 1'b1, '{32'sd0, STAT_FEW,   10'd0, 10'd0}},
      '{MODE_ROT_DOWN,   DQ_B, 32'sd0, 1'b1, '{32'sd0, STAT_EMPTY, 10'd0, 10'd0}},
      '{MODE_ROT_UP,     DQ_A, 32'sd0, 1'b1, '{32'sd0, STAT_EMPTY, 10'd0, 10'd0}},
      '{MODE_TRANSFER,   DQ_A, 32'sd0, 1'b1, '{32'sd0, STAT_EMPTY, 10'd0, 10'd0}},
      '{MODE_PUSH_BACK,  DQ_A, MAXV,   1'b1, '{32'sd0, STAT_OK,    10'd1, 10'd0}},
      '{MODE_SWAP,       DQ_A, 32'sd0, 1'b1, '{32'sd0, STAT_FEW,   10'd1, 10'd0}},
      '{MODE_ROT_DOWN,   DQ_A, 32'sd0, 1'b1, '{MAXV,   STAT_OK,    10'd1, 10'd0}},
      '{MODE_ROT_UP,     DQ_A, 32'sd0, 1'b1, '{MAXV,   STAT_OK,    10'd1, 10'd0}},
      '{MODE_PUSH_FRONT, DQ_A, MINV,   1'b1, '{32'sd0, STAT_OK,    10'd2, 10'd0}},
      '{MODE_SWAP,       DQ_A, 32'sd0, 1'b1, '{MINV,   STAT_OK,    10'd2, 10'd0}},
      '{MODE_POP_BACK,   DQ_A, 32'sd0, 1'b1, '{MINV,   STAT_OK,    10'd1, 10'd0}},
      '{MODE_PUSH_BACK,  DQ_B, -32'sd1, 1'b1, '{32'sd0, STAT_OK,   10'd1, 10'd1}},
      '{MODE_PUSH_FRONT, DQ_B, 32'sd0, 1'b1, '{32'sd0, STAT_OK,    10'd1, 10'd2}},
      '{MODE_TRANSFER,   DQ_B, 32'sd0, 1'b1, '{-32'sd1, STAT_OK,   10'd2, 10'd1}},
      '{MODE_TRANSFER,   DQ_A, 32'sd0, 1'b1, '{-32'sd1, STAT_OK,   10'd1, 10'd2}},
      '{MODE_ROT_DOWN,   DQ_B, 32'sd0, 1'b0, NO_RES},
      '{MODE_ROT_UP,     DQ_B, 32'sd0, 1'b0, NO_RES},
      '{MODE_POP_FRONT,  DQ_A, 32'sd0, 1'b1, '{MAXV,   STAT_OK,    10'd0, 10'd2}},
      '{MODE_POP_FRONT,  DQ_B, 32'sd0, 1'b0, NO_RES},
      '{MODE_PUSH_BACK,  DQ_A, 32'sh55555555, 1'b0, NO_RES},
      '{MODE_PUSH_FRONT, DQ_B, 32'shaaaaaaaa, 1'b0, NO_RES},
      '{MODE_POP_BACK,   DQ_B, 32'sd0, 1'b0, NO_RES},
      '{MODE_SWAP,       DQ_B, 32'sd0, 1'b0, NO_RES}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_word(plan[i].m, plan[i].s, plan[i].v, plan[i].typed, plan[i].want);
    end

    // fill A to capacity, wrapping both ends of the ring
    while (fill[0] < DEPTH_CNT) begin
      if ($urandom_range(0, 9) < 9) begin
        send_word($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, DQ_A,
                  $urandom, 1'b0, NO_RES);
      end else begin
        send_random(30);
      end
    end

    send_word(MODE_PUSH_BACK, DQ_A, $urandom, 1'b0, NO_RES);
    send_word(MODE_PUSH_FRONT, DQ_A, $urandom, 1'b0, NO_RES);
    while (fill[1] != 0) send_word(MODE_POP_FRONT, DQ_B, $urandom, 1'b0, NO_RES);
    send_word(MODE_TRANSFER, DQ_B, $urandom, 1'b1, '{32'sd0, STAT_EMPTY, DEPTH_CNT, 10'd0});
    send_word(MODE_PUSH_BACK, DQ_B, $urandom, 1'b0, NO_RES);
    send_word(MODE_TRANSFER, DQ_B, $urandom, 1'b0, NO_RES);
    send_word(MODE_SWAP, DQ_A, $urandom, 1'b0, NO_RES);
    send_word(MODE_ROT_DOWN, DQ_A, $urandom, 1'b0, NO_RES);
    send_word(MODE_ROT_UP, DQ_A, $urandom, 1'b0, NO_RES);
    send_word(MODE_TRANSFER, DQ_A, $urandom, 1'b0, NO_RES);

    repeat (150) send_random(25);

    push <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
